// ===== design/assert_macros.svh =====
// Assertion macros, used by the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked implication, off while reset is asserted.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/wsfd_pkg.sv =====
// Types, constants and the arctangent table of the windowed-sinc FIR designer.
package wsfd_pkg;

  localparam int MAX_TAPS_DEF   = 64;
  localparam int COEF_WIDTH_DEF = 32;

  localparam int SR_W   = 24;
  localparam int FREQ_W = 24;
  localparam int ORD_W  = 6;
  localparam int TIDX_W = 6;
  localparam int COEF_W = 32;
  localparam int VAL_W  = 64;
  localparam int SUM_W  = 40;
  localparam int MUL_W  = 34;
  localparam int PROD_W = 68;
  localparam int DIVD_W = 64;
  localparam int DIVS_W = 40;
  localparam int CRD_W  = 34;
  localparam int ANG_W  = 32;
  localparam int CORDIC_STEPS = 30;

  localparam logic [SR_W-1:0] SR_RESET = 24'd48000;

  localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [MUL_W-1:0] INV_PI_Q32  = 34'sd1367130551;
  localparam logic signed [MUL_W-1:0] HAM_A_Q30   = 34'sd579820585;
  localparam logic signed [MUL_W-1:0] HAM_B_Q30   = 34'sd493921239;
  localparam logic signed [VAL_W-1:0] ONE_Q30     = 64'sd1073741824;

  typedef enum logic [1:0] {
    FN_LOWPASS  = 2'd0,
    FN_HIGHPASS = 2'd1,
    FN_BANDPASS = 2'd2,
    FN_BANDSTOP = 2'd3
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [FREQ_W-1:0]  first_cutoff;
    logic [FREQ_W-1:0]  second_cutoff;
    logic [ORD_W-1:0]   filter_order;
  } req_beat_t;

  typedef struct packed {
    logic [TIDX_W-1:0]        tap_index;
    logic signed [COEF_W-1:0] coefficient;
    logic                     last_tap;
  } tap_beat_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_LP_START,
    OP_RQ_LATCH,
    OP_ANG2_DIV,
    OP_ANG2_LATCH,
    OP_H_CENTRE,
    OP_MUL_RK,
    OP_CORDIC_SINC,
    OP_MUL_SPI,
    OP_DIV_K,
    OP_H_LATCH,
    OP_CORDIC_WIN,
    OP_MUL_HB,
    OP_W_LATCH,
    OP_MUL_HW,
    OP_TAP_STORE,
    OP_NORM_START,
    OP_NORM_READ,
    OP_NORM_DIV,
    OP_NORM_WRITE,
    OP_SEL_B,
    OP_OUT_START,
    OP_OUT_READ,
    OP_OUT_LOAD
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic cordic_done;
    logic k_zero;
    logic n_last;
    logic sum_pos;
    logic dual;
    logic sel_b;
    logic out_free;
  } status_t;

  // atan(2^-i) as a fraction of a turn, 2^32 per turn
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'h20000000;
      5'd1:  r = 30'h12E4051D;
      5'd2:  r = 30'h09FB385B;
      5'd3:  r = 30'h051111D4;
      5'd4:  r = 30'h028B0D43;
      5'd5:  r = 30'h0145D7E1;
      5'd6:  r = 30'h00A2F61E;
      5'd7:  r = 30'h00517C55;
      5'd8:  r = 30'h0028BE53;
      5'd9:  r = 30'h00145F2E;
      5'd10: r = 30'h000A2F98;
      5'd11: r = 30'h000517CC;
      5'd12: r = 30'h00028BE6;
      5'd13: r = 30'h000145F3;
      5'd14: r = 30'h0000A2F9;
      5'd15: r = 30'h0000517C;
      5'd16: r = 30'h000028BE;
      5'd17: r = 30'h0000145F;
      5'd18: r = 30'h00000A2F;
      5'd19: r = 30'h00000517;
      5'd20: r = 30'h0000028B;
      5'd21: r = 30'h00000145;
      5'd22: r = 30'h000000A2;
      5'd23: r = 30'h00000051;
      5'd24: r = 30'h00000028;
      5'd25: r = 30'h00000014;
      5'd26: r = 30'h0000000A;
      5'd27: r = 30'h00000005;
      5'd28: r = 30'h00000002;
      5'd29: r = 30'h00000001;
      default: r = 30'h0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/windowed_sinc_fir_designer.sv =====
// Top level of the Hamming-windowed sinc FIR tap designer.
//
//  channel | handshake             | payload    | beat
//  --------+-----------------------+------------+-----------------------------------
//  req     | req_valid / req_ready | req        | one design request
//  tap     | tap_valid / tap_ready | tap        | one coefficient, last_tap on final
//  cfg     | cfg_we                | cfg_wdata  | sample_rate write, no wait
//
// Flow: one request is worked at a time. Each tap of a lowpass prototype takes
//   two passes through the 64-step divider and two through the 30-step CORDIC (the
//   centre tap one of each); normalization adds one divider pass per tap.
//   Bandpass and bandstop design two prototypes.
// Reset: synchronous, active high; sample_rate returns to 48000 Hz.
// Stalls: the tap register holds a beat until taken; the sequencer waits there.
//   req_ready rises again as soon as the last tap is loaded into the tap register.
module windowed_sinc_fir_designer
  import wsfd_pkg::*;
#(
  parameter int MAX_TAPS   = MAX_TAPS_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  req_beat_t       req,
  output logic            tap_valid,
  input  logic            tap_ready,
  output tap_beat_t       tap,
  input  logic            cfg_we,
  input  logic [SR_W-1:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  // sequencer: owns the request handshake and issues at most one datapath op per cycle
  wsfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: divider, CORDIC, multiplier, tap memories, output register
  wsfd_dp #(
    .MAX_TAPS   (MAX_TAPS),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .tap       (tap),
    .tap_valid (tap_valid),
    .tap_ready (tap_ready)
  );

endmodule

// ===== design/wsfd_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
module wsfd_div
  import wsfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [DIVD_W-1:0] quo;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dsr;
  logic [DIVS_W:0]   r_sh;
  logic [DIVS_W+1:0] diff;
  logic              ge;
  logic [DIVS_W-1:0] rem_next;

  always_comb begin
    r_sh     = {rem, quo[DIVD_W-1]};
    diff     = {1'b0, r_sh} - {2'b00, dsr};
    ge       = ~diff[DIVS_W+1];
    rem_next = ge ? diff[DIVS_W-1:0] : r_sh[DIVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVD_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

// ===== design/wsfd_cordic.sv =====
// Iterative rotation CORDIC: cosine and sine of a turn fraction in Q30.
module wsfd_cordic
  import wsfd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [ANG_W-1:0]        angle,
  output logic                    busy,
  output logic                    done,
  output logic signed [CRD_W-1:0] cos_out,
  output logic signed [CRD_W-1:0] sin_out
);

  logic [4:0]              step;
  logic                    flip;
  logic signed [CRD_W-1:0] x, y, z;
  logic signed [CRD_W-1:0] dx, dy, at;
  logic signed [CRD_W-1:0] x_next, y_next, z_next;
  logic [ANG_W-1:0]        fold_t, ang_f;
  logic                    fold;

  always_comb begin
    fold_t = angle + 32'h4000_0000;
    fold   = fold_t[ANG_W-1];
    ang_f  = fold ? (angle + 32'h8000_0000) : angle;
    dx     = y >>> step;
    dy     = x >>> step;
    at     = {4'b0000, atan_turn(step)};
    if (!z[CRD_W-1]) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - at;
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == 5'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= {{(CRD_W-ANG_W){ang_f[ANG_W-1]}}, ang_f};
      flip <= fold;
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
      if (step == 5'(CORDIC_STEPS - 1)) begin
        cos_out <= flip ? -x_next : x_next;
        sin_out <= flip ? -y_next : y_next;
      end
    end
  end

endmodule

// ===== design/wsfd_dp.sv =====
// Datapath: request registers, multiplier, divider, CORDIC, tap memories, output register.
`include "assert_macros.svh"

module wsfd_dp
  import wsfd_pkg::*;
#(
  parameter int MAX_TAPS   = MAX_TAPS_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  cmd_t            cmd,
  output status_t         status,
  input  req_beat_t       req,
  input  logic            cfg_we,
  input  logic [SR_W-1:0] cfg_wdata,
  output tap_beat_t       tap,
  output logic            tap_valid,
  input  logic            tap_ready
);

  localparam int AW  = $clog2(MAX_TAPS);
  localparam int CBW = VAL_W + 2;
  localparam int XW  = CBW + 16;
  localparam int SHL = (COEF_WIDTH >= 32) ? COEF_WIDTH - 32 : 0;
  localparam int SHR = (COEF_WIDTH < 32) ? 32 - COEF_WIDTH : 0;
  localparam int RSH = (SHR > 0) ? SHR - 1 : 0;
  localparam logic signed [XW-1:0] SAT_HI = (XW'(1) <<< (COEF_WIDTH - 1)) - XW'(1);
  localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;

  logic [SR_W-1:0]          sample_rate;
  func_t                    fn;
  logic [FREQ_W-1:0]        f1, f2;
  logic [ORD_W-1:0]         order, centre, n;
  logic                     sel_b;
  logic [ANG_W-1:0]         rq, ang2;
  logic signed [PROD_W-1:0] prod;
  logic signed [MUL_W-1:0]  h, w;
  logic signed [SUM_W-1:0]  sum;
  logic signed [VAL_W-1:0]  rd_a, rd_b;
  logic signed [VAL_W-1:0]  mem_a [MAX_TAPS];
  logic signed [VAL_W-1:0]  mem_b [MAX_TAPS];
  logic [AW-1:0]            addr;

  logic [ORD_W-1:0]         ord_sat;
  logic signed [ORD_W:0]    k;
  logic [ORD_W:0]           k_mag;
  logic signed [MUL_W-1:0]  ma, mb;
  logic                     div_start, div_busy, div_done;
  logic [DIVD_W-1:0]        div_dvd, div_q;
  logic [DIVS_W-1:0]        div_dvs;
  logic [SR_W-1:0]          fs_eff;
  logic [FREQ_W-1:0]        cutoff;
  logic [PROD_W-1:0]        prod_mag;
  logic                     h_neg;
  logic signed [DIVD_W:0]   q_sgn;
  logic signed [DIVD_W:0]   h_rnd;
  logic signed [PROD_W-1:0] p_rnd;
  logic signed [VAL_W-1:0]  rd_sel, rd_mag, norm_val;
  logic                     crd_start, crd_busy, crd_done;
  logic [ANG_W-1:0]         crd_ang;
  logic signed [CRD_W-1:0]  crd_cos, crd_sin;
  logic signed [CBW-1:0]    ca, cb, cd, comb_v;
  logic signed [XW-1:0]     vx, vs, vsat;
  logic                     mem_we;
  logic signed [VAL_W-1:0]  mem_wd;

  // ---- request decode ----
  always_comb begin
    if (req.filter_order < ORD_W'(2)) begin
      ord_sat = ORD_W'(2);
    end else if (req.filter_order > ORD_W'(MAX_TAPS - 1)) begin
      ord_sat = ORD_W'(MAX_TAPS - 1);
    end else begin
      ord_sat = req.filter_order;
    end
  end

  assign k      = signed'({1'b0, n}) - signed'({1'b0, centre});
  assign k_mag  = k[ORD_W] ? ORD_W'(0) - k : k;
  assign fs_eff = (sample_rate == '0) ? SR_W'(1) : sample_rate;
  assign cutoff = sel_b ? f2 : f1;
  assign addr   = n[AW-1:0];

  // ---- multiplier operand select ----
  always_comb begin
    unique case (cmd.op)
      OP_MUL_RK: begin
        ma = {2'b00, rq};
        mb = {{(MUL_W-ORD_W-1){k[ORD_W]}}, k};
      end
      OP_MUL_SPI: begin
        ma = crd_sin;
        mb = INV_PI_Q32;
      end
      OP_MUL_HB: begin
        ma = crd_cos;
        mb = HAM_B_Q30;
      end
      OP_MUL_HW: begin
        ma = h;
        mb = w;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // ---- divider operand select ----
  always_comb begin
    prod_mag = prod[PROD_W-1] ? PROD_W'(0) - prod : prod;
    rd_sel   = sel_b ? rd_b : rd_a;
    rd_mag   = rd_sel[VAL_W-1] ? VAL_W'(0) - rd_sel : rd_sel;
    div_dvd  = '0;
    div_dvs  = '0;
    unique case (cmd.op)
      OP_LP_START: begin
        div_dvd = {8'h00, cutoff, 32'h0};
        div_dvs = {16'h0000, fs_eff};
      end
      OP_ANG2_DIV: begin
        div_dvd = {26'h0, n, 32'h0};
        div_dvs = {34'h0, order};
      end
      OP_DIV_K: begin
        div_dvd = prod_mag[DIVD_W-1:0];
        div_dvs = {33'h0, k_mag};
      end
      OP_NORM_DIV: begin
        div_dvd = (rd_mag << 30) + {25'h0, sum[SUM_W-1:1]};
        div_dvs = sum;
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  assign div_start = (cmd.op == OP_LP_START) || (cmd.op == OP_ANG2_DIV) ||
                     (cmd.op == OP_DIV_K) || (cmd.op == OP_NORM_DIV);

  wsfd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign crd_start = (cmd.op == OP_CORDIC_SINC) || (cmd.op == OP_CORDIC_WIN);
  assign crd_ang   = (cmd.op == OP_CORDIC_SINC) ? prod[ANG_W-1:0] : ang2;

  wsfd_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (crd_start),
    .angle   (crd_ang),
    .busy    (crd_busy),
    .done    (crd_done),
    .cos_out (crd_cos),
    .sin_out (crd_sin)
  );

  // ---- rounding of results ----
  always_comb begin
    h_neg    = prod[PROD_W-1] ^ k[ORD_W];
    q_sgn    = h_neg ? -signed'({1'b0, div_q}) : signed'({1'b0, div_q});
    h_rnd    = (q_sgn + (65'sd1 <<< 31)) >>> 32;
    p_rnd    = (prod + (68'sd1 <<< 29)) >>> 30;
    norm_val = rd_sel[VAL_W-1] ? VAL_W'(0) - div_q : div_q;
  end

  // ---- register file ----
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= SR_RESET;
    end else if (cfg_we) begin
      sample_rate <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_INIT: begin
        fn     <= req.func;
        f1     <= req.first_cutoff;
        f2     <= req.second_cutoff;
        order  <= ord_sat;
        centre <= ord_sat >> 1;
        sel_b  <= 1'b0;
      end
      OP_LP_START: begin
        sum <= '0;
        n   <= '0;
      end
      OP_RQ_LATCH:   rq <= (div_q > 64'h8000_0000) ? 32'h8000_0000 : div_q[ANG_W-1:0];
      OP_ANG2_LATCH: ang2 <= div_q[ANG_W-1:0];
      OP_H_CENTRE:   h <= {3'b000, rq[ANG_W-1:1]};
      OP_MUL_RK, OP_MUL_SPI, OP_MUL_HB, OP_MUL_HW: prod <= ma * mb;
      OP_H_LATCH:    h <= h_rnd[MUL_W-1:0];
      OP_W_LATCH:    w <= HAM_A_Q30 - p_rnd[MUL_W-1:0];
      OP_TAP_STORE: begin
        sum <= sum + p_rnd[SUM_W-1:0];
        n   <= n + 1'b1;
      end
      OP_NORM_START, OP_OUT_START: n <= '0;
      OP_NORM_WRITE, OP_OUT_LOAD:  n <= n + 1'b1;
      OP_SEL_B: sel_b <= 1'b1;
      default: ;
    endcase
  end

  // ---- tap memories ----
  assign mem_we = (cmd.op == OP_TAP_STORE) || (cmd.op == OP_NORM_WRITE);
  assign mem_wd = (cmd.op == OP_TAP_STORE) ? p_rnd[VAL_W-1:0] : norm_val;

  always_ff @(posedge clk) begin
    if (mem_we && !sel_b) begin
      mem_a[addr] <= mem_wd;
    end
    if (cmd.op == OP_NORM_READ || cmd.op == OP_OUT_READ) begin
      rd_a <= mem_a[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we && sel_b) begin
      mem_b[addr] <= mem_wd;
    end
    if (cmd.op == OP_NORM_READ || cmd.op == OP_OUT_READ) begin
      rd_b <= mem_b[addr];
    end
  end

  // ---- band combination and output scaling ----
  always_comb begin
    ca = {{2{rd_a[VAL_W-1]}}, rd_a};
    cb = {{2{rd_b[VAL_W-1]}}, rd_b};
    cd = (n == centre) ? {2'b00, ONE_Q30} : '0;
    unique case (fn)
      FN_LOWPASS:  comb_v = ca;
      FN_HIGHPASS: comb_v = cd - ca;
      FN_BANDPASS: comb_v = cb - ca;
      FN_BANDSTOP: comb_v = ca + cd - cb;
      default:     comb_v = ca;
    endcase
    vx = {{(XW-CBW){comb_v[CBW-1]}}, comb_v};
    if (SHR > 0) begin
      vs = (vx + (XW'(1) <<< RSH)) >>> SHR;
    end else begin
      vs = vx <<< SHL;
    end
    if (vs > SAT_HI) begin
      vsat = SAT_HI;
    end else if (vs < SAT_LO) begin
      vsat = SAT_LO;
    end else begin
      vsat = vs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_valid <= 1'b0;
    end else if (cmd.op == OP_OUT_LOAD) begin
      tap_valid <= 1'b1;
    end else if (tap_ready) begin
      tap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT_LOAD) begin
      tap.tap_index   <= n;
      tap.coefficient <= vsat[COEF_W-1:0];
      tap.last_tap    <= (n == order);
    end
  end

  // ---- status ----
  always_comb begin
    status.div_done    = div_done;
    status.cordic_done = crd_done;
    status.k_zero      = (n == centre);
    status.n_last      = (n == order);
    status.sum_pos     = !sum[SUM_W-1] && (sum != '0);
    status.dual        = (fn == FN_BANDPASS) || (fn == FN_BANDSTOP);
    status.sel_b       = sel_b;
    status.out_free    = !tap_valid || tap_ready;
  end

  `ASSERT_IMP(a_div_start_idle, div_start, !div_busy, "divider restarted while busy")
  `ASSERT_IMP(a_crd_start_idle, crd_start, !crd_busy, "cordic restarted while busy")
  `ASSERT_IMP(a_out_load_free, cmd.op == OP_OUT_LOAD, !tap_valid || tap_ready,
              "tap register overwritten before it was taken")

endmodule

// ===== design/wsfd_ctrl.sv =====
// Sequencer: steps the datapath through prototype design, normalization and output.
module wsfd_ctrl
  import wsfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [24:0] {
    S_IDLE    = 25'h0000001,
    S_LP_RQ   = 25'h0000002,
    S_LP_RQ_W = 25'h0000004,
    S_T_ANG   = 25'h0000008,
    S_T_ANG_W = 25'h0000010,
    S_T_HC    = 25'h0000020,
    S_T_MRK   = 25'h0000040,
    S_T_CS    = 25'h0000080,
    S_T_CS_W  = 25'h0000100,
    S_T_MSP   = 25'h0000200,
    S_T_DK    = 25'h0000400,
    S_T_DK_W  = 25'h0000800,
    S_T_CW    = 25'h0001000,
    S_T_CW_W  = 25'h0002000,
    S_T_MHB   = 25'h0004000,
    S_T_WL    = 25'h0008000,
    S_T_MHW   = 25'h0010000,
    S_T_ST    = 25'h0020000,
    S_N_CHK   = 25'h0040000,
    S_N_RD    = 25'h0080000,
    S_N_DV    = 25'h0100000,
    S_N_DV_W  = 25'h0200000,
    S_L_END   = 25'h0400000,
    S_O_RD    = 25'h0800000,
    S_O_LD    = 25'h1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: if (req_valid) begin
        cmd.op     = OP_INIT;
        state_next = S_LP_RQ;
      end
      S_LP_RQ: begin
        cmd.op     = OP_LP_START;
        state_next = S_LP_RQ_W;
      end
      S_LP_RQ_W: if (status.div_done) begin
        cmd.op     = OP_RQ_LATCH;
        state_next = S_T_ANG;
      end
      S_T_ANG: begin
        cmd.op     = OP_ANG2_DIV;
        state_next = S_T_ANG_W;
      end
      S_T_ANG_W: if (status.div_done) begin
        cmd.op     = OP_ANG2_LATCH;
        state_next = status.k_zero ? S_T_HC : S_T_MRK;
      end
      S_T_HC: begin
        cmd.op     = OP_H_CENTRE;
        state_next = S_T_CW;
      end
      S_T_MRK: begin
        cmd.op     = OP_MUL_RK;
        state_next = S_T_CS;
      end
      S_T_CS: begin
        cmd.op     = OP_CORDIC_SINC;
        state_next = S_T_CS_W;
      end
      S_T_CS_W: if (status.cordic_done) begin
        state_next = S_T_MSP;
      end
      S_T_MSP: begin
        cmd.op     = OP_MUL_SPI;
        state_next = S_T_DK;
      end
      S_T_DK: begin
        cmd.op     = OP_DIV_K;
        state_next = S_T_DK_W;
      end
      S_T_DK_W: if (status.div_done) begin
        cmd.op     = OP_H_LATCH;
        state_next = S_T_CW;
      end
      S_T_CW: begin
        cmd.op     = OP_CORDIC_WIN;
        state_next = S_T_CW_W;
      end
      S_T_CW_W: if (status.cordic_done) begin
        state_next = S_T_MHB;
      end
      S_T_MHB: begin
        cmd.op     = OP_MUL_HB;
        state_next = S_T_WL;
      end
      S_T_WL: begin
        cmd.op     = OP_W_LATCH;
        state_next = S_T_MHW;
      end
      S_T_MHW: begin
        cmd.op     = OP_MUL_HW;
        state_next = S_T_ST;
      end
      S_T_ST: begin
        cmd.op     = OP_TAP_STORE;
        state_next = status.n_last ? S_N_CHK : S_T_ANG;
      end
      S_N_CHK: begin
        if (status.sum_pos) begin
          cmd.op     = OP_NORM_START;
          state_next = S_N_RD;
        end else begin
          state_next = S_L_END;
        end
      end
      S_N_RD: begin
        cmd.op     = OP_NORM_READ;
        state_next = S_N_DV;
      end
      S_N_DV: begin
        cmd.op     = OP_NORM_DIV;
        state_next = S_N_DV_W;
      end
      S_N_DV_W: if (status.div_done) begin
        cmd.op     = OP_NORM_WRITE;
        state_next = status.n_last ? S_L_END : S_N_RD;
      end
      S_L_END: begin
        if (status.dual && !status.sel_b) begin
          cmd.op     = OP_SEL_B;
          state_next = S_LP_RQ;
        end else begin
          cmd.op     = OP_OUT_START;
          state_next = S_O_RD;
        end
      end
      S_O_RD: begin
        cmd.op     = OP_OUT_READ;
        state_next = S_O_LD;
      end
      S_O_LD: if (status.out_free) begin
        cmd.op     = OP_OUT_LOAD;
        state_next = status.n_last ? S_IDLE : S_O_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
